@@ hw/rtl/bmpblt_pkg.sv @@
// Shared constants and types for the BMP-to-framebuffer blit block.
`default_nettype none

package bmpblt_pkg;

    // Default screen geometry
    localparam int unsigned SCREEN_WIDTH_DEF  = 800;
    localparam int unsigned SCREEN_HEIGHT_DEF = 480;

    // BMP header layout
    localparam logic [5:0] HEADER_BYTES = 6'd54;
    localparam logic [5:0] WIDTH_OFS    = 6'd18;
    localparam logic [5:0] HEIGHT_OFS   = 6'd22;

    // Field widths
    localparam int unsigned ORIGIN_X_W = 10;
    localparam int unsigned ORIGIN_Y_W = 9;
    localparam int unsigned ADDR_W     = 19;
    localparam int unsigned ARGB_W     = 24;
    localparam int unsigned M_DATA_W   = 48;

    // Configuration register indexes
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    // One placed pixel between parser and placement stages
    typedef struct packed {
        logic [32:0]       sx;    // screen column, unbounded
        logic [32:0]       sy;    // screen row, unbounded
        logic [ARGB_W-1:0] argb;  // red, green, blue from high to low
        logic              last;  // final pixel of the image
    } pix_t;

endpackage

`default_nettype wire

@@ hw/rtl/bmp24_framebuffer_blit.sv @@
// Top level: 24-bit BMP byte stream to ARGB framebuffer write stream.
//
// Usage:
//   s_ channel carries one file byte per transfer; s_tuser marks the first
//   byte of a file and restarts header parsing. The 54-byte header supplies
//   width and height; then each B,G,R triple up to the last pixel of a nonempty image yields one m_ transfer.
//   m_ channel carries one framebuffer write per pixel: m_tuser is the
//   visible flag (clipped pixels show 0 and address 0), m_tlast marks the
//   image's final pixel. Rows are flipped from bottom-up file order and
//   placed at (origin_x, origin_y) on the screen.
//   cfg_ channel writes origin_x (index 0) and origin_y (index 1); it is
//   always ready; the user must write it only while the stream is idle, which the block itself leaves unchecked.
// Timing:
//   One byte per cycle sustained while m_tready is high. A result reaches
//   m_ after the red byte's transfer by way of the parser's pixel register
//   and then the placement stage's output register.
//   If m_tready stays low, the output register and the pixel register fill
//   and s_tready drops; header and padding-free color bytes that give no
//   result still pass while the pixel register is empty.
//   Reset clears origins, dimensions, counters and both valid registers.
`default_nettype none

module bmp24_framebuffer_blit #(
    parameter int unsigned SCREEN_WIDTH  = bmpblt_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = bmpblt_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // s_tdata: [7:0] file_byte
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,
    // s_tuser: [0] first_byte
    input  wire logic                                s_tuser,
    // m_tdata: [18:0] write_address, [42:19] pixel_argb, [47:43] zero
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [bmpblt_pkg::M_DATA_W-1:0]          m_tdata,
    // m_tuser: [0] visible
    output logic                                     m_tuser,
    output logic                                     m_tlast,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic                                cfg_index,
    input  wire logic [bmpblt_pkg::ORIGIN_X_W-1:0]   cfg_data
);
    import bmpblt_pkg::*;

    logic [ORIGIN_X_W-1:0] origin_x_reg;
    logic [ORIGIN_Y_W-1:0] origin_y_reg;

    logic              pix_valid;
    logic              pix_ready;
    pix_t              pix;
    logic [ADDR_W-1:0] out_addr;
    logic [ARGB_W-1:0] out_argb;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ORIGIN_X: origin_x_reg <= cfg_data;
                CFG_ORIGIN_Y: origin_y_reg <= cfg_data[ORIGIN_Y_W-1:0];
                default:      origin_x_reg <= origin_x_reg;
            endcase
        end
    end

    bmpblt_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .file_byte  (s_tdata),
        .first_byte (s_tuser),
        .origin_x   (origin_x_reg),
        .origin_y   (origin_y_reg),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix        (pix)
    );

    bmpblt_place #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_place (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .pix         (pix),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_visible (m_tuser),
        .out_addr    (out_addr),
        .out_argb    (out_argb),
        .out_last    (m_tlast)
    );

    // Pack output data, zero-fill to whole bytes
    assign m_tdata = {(M_DATA_W - ADDR_W - ARGB_W)'(0), out_argb, out_addr};

    // Clipped pixels carry a zero address
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[ADDR_W-1:0] == '0))
        else $error("clipped pixel with nonzero address");

    // Visible pixels stay inside the framebuffer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |->
            (32'(m_tdata[ADDR_W-1:0]) < 32'(SCREEN_WIDTH * SCREEN_HEIGHT)))
        else $error("visible pixel address beyond framebuffer");

    // Output stage empties on reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire

@@ hw/rtl/bmpblt_parser.sv @@
// Byte parser: header capture, B/G/R packing, row flip and pixel register.
`default_nettype none

module bmpblt_parser (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [7:0]                          file_byte,
    input  wire logic                                first_byte,
    input  wire logic [bmpblt_pkg::ORIGIN_X_W-1:0]   origin_x,
    input  wire logic [bmpblt_pkg::ORIGIN_Y_W-1:0]   origin_y,
    output logic                                     pix_valid,
    input  wire logic                                pix_ready,
    output bmpblt_pkg::pix_t                         pix
);
    import bmpblt_pkg::*;

    logic [5:0]  hdr_pos_reg,  hdr_pos_next;
    logic [31:0] width_reg,    width_next;
    logic [31:0] height_reg,   height_next;
    logic [1:0]  phase_reg,    phase_next;
    logic [7:0]  blue_reg,     blue_next;
    logic [7:0]  green_reg,    green_next;
    logic [31:0] col_reg,      col_next;
    logic [31:0] row_reg,      row_next;
    logic        done_reg,     done_next;
    logic        pvalid_reg,   pvalid_next;
    pix_t        pix_reg,      pix_next;

    logic        accept;
    logic [5:0]  hdr_pos;
    logic [1:0]  phase;
    logic [31:0] col;
    logic [31:0] row;
    logic        done;
    logic [5:0]  wsel;
    logic [5:0]  hsel;
    logic        col_end;
    logic        is_last;
    logic        emit;
    logic [31:0] flip_row;

    // Stage advances when empty or when its pixel is taken
    assign in_ready  = !pvalid_reg || pix_ready;
    assign accept    = in_valid && in_ready;
    assign pix_valid = pvalid_reg;
    assign pix       = pix_reg;

    // Restart parsing on the first byte of a new file
    assign hdr_pos = first_byte ? 6'd0  : hdr_pos_reg;
    assign phase   = first_byte ? 2'd0  : phase_reg;
    assign col     = first_byte ? 32'd0 : col_reg;
    assign row     = first_byte ? 32'd0 : row_reg;
    assign done    = first_byte ? 1'b0  : done_reg;

    assign wsel     = hdr_pos - WIDTH_OFS;
    assign hsel     = hdr_pos - HEIGHT_OFS;
    assign col_end  = (col == width_reg - 32'd1);
    assign is_last  = col_end && (row == height_reg - 32'd1);
    assign flip_row = height_reg - 32'd1 - row;

    // Next state for header, pixel assembly and counters
    always_comb begin
        hdr_pos_next = hdr_pos_reg;
        width_next   = width_reg;
        height_next  = height_reg;
        phase_next   = phase_reg;
        blue_next    = blue_reg;
        green_next   = green_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        done_next    = done_reg;
        emit         = 1'b0;
        if (accept) begin
            hdr_pos_next = hdr_pos;
            phase_next   = phase;
            col_next     = col;
            row_next     = row;
            done_next    = done;
            if (hdr_pos < HEADER_BYTES) begin
                if (hdr_pos >= WIDTH_OFS && hdr_pos < HEIGHT_OFS) begin
                    width_next[{wsel[1:0], 3'b000} +: 8] = file_byte;
                end else if (hdr_pos >= HEIGHT_OFS && hdr_pos < HEIGHT_OFS + 6'd4) begin
                    height_next[{hsel[1:0], 3'b000} +: 8] = file_byte;
                end
                hdr_pos_next = hdr_pos + 6'd1;
            end else if (!done && width_reg != 32'd0 && height_reg != 32'd0) begin
                case (phase)
                    2'd0: begin
                        blue_next  = file_byte;
                        phase_next = 2'd1;
                    end
                    2'd1: begin
                        green_next = file_byte;
                        phase_next = 2'd2;
                    end
                    default: begin
                        phase_next = 2'd0;
                        emit       = 1'b1;
                        if (is_last) begin
                            done_next = 1'b1;
                        end else if (col_end) begin
                            col_next = 32'd0;
                            row_next = row + 32'd1;
                        end else begin
                            col_next = col + 32'd1;
                        end
                    end
                endcase
            end
        end
    end

    // Load the pixel register on a completed triple
    always_comb begin
        pvalid_next = pvalid_reg;
        if (pix_ready) begin
            pvalid_next = 1'b0;
        end
        if (emit) begin
            pvalid_next = 1'b1;
        end
        pix_next      = pix_reg;
        pix_next.sx   = 33'(origin_x) + 33'(col);
        pix_next.sy   = 33'(origin_y) + 33'(flip_row);
        pix_next.argb = {file_byte, green_reg, blue_reg};
        pix_next.last = is_last;
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_pos_reg <= '0;
            width_reg   <= '0;
            height_reg  <= '0;
            phase_reg   <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
            pvalid_reg  <= 1'b0;
            blue_reg    <= '0;
            green_reg   <= '0;
        end else begin
            hdr_pos_reg <= hdr_pos_next;
            width_reg   <= width_next;
            height_reg  <= height_next;
            phase_reg   <= phase_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            done_reg    <= done_next;
            pvalid_reg  <= pvalid_next;
            blue_reg    <= blue_next;
            green_reg   <= green_next;
        end
    end

    // Capture pixel payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            pix_reg <= pix_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bmpblt_place.sv @@
// Placement stage: clip test, framebuffer address and output register.
`default_nettype none

module bmpblt_place #(
    parameter int unsigned SCREEN_WIDTH  = bmpblt_pkg::SCREEN_WIDTH_DEF,
    parameter int unsigned SCREEN_HEIGHT = bmpblt_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             pix_valid,
    output logic                                  pix_ready,
    input  wire bmpblt_pkg::pix_t                 pix,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  out_visible,
    output logic [bmpblt_pkg::ADDR_W-1:0]         out_addr,
    output logic [bmpblt_pkg::ARGB_W-1:0]         out_argb,
    output logic                                  out_last
);
    import bmpblt_pkg::*;

    localparam int unsigned XW = $clog2(SCREEN_WIDTH);
    localparam int unsigned YW = $clog2(SCREEN_HEIGHT);

    logic              valid_reg, valid_next;
    logic              vis_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ARGB_W-1:0] argb_reg;
    logic              last_reg;

    logic              load;
    logic              vis;
    logic [31:0]       row_base;
    logic [ADDR_W-1:0] addr;

    assign pix_ready = !valid_reg || out_ready;
    assign load      = pix_valid && pix_ready;

    // Clip against the screen and form the word address
    assign vis      = (pix.sx < 33'(SCREEN_WIDTH)) && (pix.sy < 33'(SCREEN_HEIGHT));
    assign row_base = 32'(SCREEN_WIDTH) * 32'(pix.sy[YW-1:0]);
    assign addr     = vis ? (row_base[ADDR_W-1:0] + ADDR_W'(pix.sx[XW-1:0])) : '0;

    always_comb begin
        valid_next = valid_reg;
        if (out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    // Hold output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture result payload
    always_ff @(posedge aclk) begin
        if (load) begin
            vis_reg  <= vis;
            addr_reg <= addr;
            argb_reg <= pix.argb;
            last_reg <= pix.last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_visible = vis_reg;
    assign out_addr    = addr_reg;
    assign out_argb    = argb_reg;
    assign out_last    = last_reg;

endmodule

`default_nettype wire

@@ verif/bmp24_framebuffer_blit_test.sv @@
// Testbench for bmp24_framebuffer_blit: streams BMP files and checks every framebuffer write.
module bmp24_framebuffer_blit_test;
    import bmpblt_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int ITEM_TARGET  = 1600;

    // One framebuffer write as seen on the m_ channel
    typedef struct packed {
        logic              visible;
        logic [ADDR_W-1:0] addr;
        logic [ARGB_W-1:0] argb;
        logic              last;
    } fb_write_t;

    // Tracks the parser and placement state, and holds the writes still owed
    class pixel_scoreboard;
        logic [ORIGIN_X_W-1:0] org_x;
        logic [ORIGIN_Y_W-1:0] org_y;
        logic [5:0]            hdr_pos;
        logic [31:0]           img_w;
        logic [31:0]           img_h;
        logic [31:0]           col;
        logic [31:0]           row;
        logic [1:0]            phase;
        logic [7:0]            blue;
        logic [7:0]            green;
        bit                    done;
        fb_write_t             expected_writes[$];
        int                    errors;

        function new();
            org_x   = '0;
            org_y   = '0;
            hdr_pos = '0;
            img_w   = '0;
            img_h   = '0;
            col     = '0;
            row     = '0;
            phase   = '0;
            blue    = '0;
            green   = '0;
            done    = 1'b0;
            errors  = 0;
        endfunction

        function void set_origin(logic idx, logic [ORIGIN_X_W-1:0] val);
            if (idx == CFG_ORIGIN_X) begin
                org_x = val;
            end else begin
                org_y = val[ORIGIN_Y_W-1:0];
            end
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        // Advance the parser by one accepted byte; return 0 when the byte is ignored
        function bit note_byte(logic [7:0] b, logic first);
            fb_write_t       w;
            logic [31:0]     flip;
            longint unsigned sx;
            longint unsigned sy;
            int              sh;
            if (first) begin
                hdr_pos = '0;
                phase   = '0;
                col     = '0;
                row     = '0;
                done    = 1'b0;
            end
            // Header: capture little-endian width and height
            if (hdr_pos < HEADER_BYTES) begin
                if (hdr_pos >= WIDTH_OFS && hdr_pos < WIDTH_OFS + 6'd4) begin
                    sh = 8 * int'(hdr_pos - WIDTH_OFS);
                    img_w[sh +: 8] = b;
                end else if (hdr_pos >= HEIGHT_OFS && hdr_pos < HEIGHT_OFS + 6'd4) begin
                    sh = 8 * int'(hdr_pos - HEIGHT_OFS);
                    img_h[sh +: 8] = b;
                end
                hdr_pos = hdr_pos + 6'd1;
                return 1'b1;
            end
            if (done || img_w == 32'd0 || img_h == 32'd0) begin
                return 1'b0;
            end
            // Collect blue and green, place the pixel on red
            if (phase == 2'd0) begin
                blue  = b;
                phase = 2'd1;
                return 1'b1;
            end
            if (phase == 2'd1) begin
                green = b;
                phase = 2'd2;
                return 1'b1;
            end
            phase     = 2'd0;
            flip      = img_h - 32'd1 - row;
            sx        = 64'(org_x) + 64'(col);
            sy        = 64'(org_y) + 64'(flip);
            w.visible = (sx < SCREEN_WIDTH_DEF) && (sy < SCREEN_HEIGHT_DEF);
            w.addr    = w.visible ? ADDR_W'(64'(SCREEN_WIDTH_DEF) * sy + sx) : '0;
            w.argb    = {b, green, blue};
            w.last    = (col == img_w - 32'd1) && (row == img_h - 32'd1);
            expected_writes.push_back(w);
            if (w.last) begin
                done = 1'b1;
            end else if (col == img_w - 32'd1) begin
                col = '0;
                row = row + 32'd1;
            end else begin
                col = col + 32'd1;
            end
            return 1'b1;
        endfunction

        // Compare one accepted write against the oldest one owed
        function void check_write(fb_write_t got, logic [M_DATA_W-ADDR_W-ARGB_W-1:0] pad);
            fb_write_t want;
            if (expected_writes.size() == 0) begin
                $error("unexpected write: address %0d, argb %06h", got.addr, got.argb);
                errors++;
                return;
            end
            want = expected_writes.pop_front();
            if (got.visible !== want.visible) begin
                $error("visible: expected %0d, got %0d", want.visible, got.visible);
                errors++;
            end
            if (got.addr !== want.addr) begin
                $error("write_address: expected %0d, got %0d", want.addr, got.addr);
                errors++;
            end
            if (got.argb !== want.argb) begin
                $error("pixel_argb: expected %06h, got %06h", want.argb, got.argb);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_pixel: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
            if (pad !== '0) begin
                $error("tdata pad: expected 0, got %0h", pad);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic                  cfg_index = CFG_ORIGIN_X;
    logic [ORIGIN_X_W-1:0] cfg_data  = '0;

    pixel_scoreboard sb = new();
    bit              steady   = 1'b0;
    bit              hold_req = 1'b0;
    int              live_items = 0;
    int              idle_cycles = 0;

    bmp24_framebuffer_blit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Mostly short idle stretches, a few long ones
    function automatic int idle_len();
        if ($urandom_range(0, 19) < 15) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Pick an origin: zero, last on-screen, off-screen, near the edge, or anywhere
    function automatic logic [ORIGIN_X_W-1:0] pick_origin(int on_max, int reg_max);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return ORIGIN_X_W'(on_max);
            2: return ORIGIN_X_W'($urandom_range(on_max + 1, reg_max));
            3: return ORIGIN_X_W'(on_max - $urandom_range(0, 15));
            default: return ORIGIN_X_W'($urandom_range(0, on_max));
        endcase
    endfunction

    // Offer one file byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = (steady || $urandom_range(0, 9) < 7) ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        live_items += int'(sb.note_byte(b, first));
    endtask

    // Send a header of hdr_len bytes carrying w and h, then body_len pixel bytes
    task automatic send_file(input logic [31:0] w, input logic [31:0] h, input int hdr_len,
                             input int body_len, input bit pattern);
        logic [7:0] b;
        int         i;
        for (i = 0; i < hdr_len; i++) begin
            if (i >= int'(WIDTH_OFS) && i < int'(WIDTH_OFS) + 4) begin
                b = w[8 * (i - int'(WIDTH_OFS)) +: 8];
            end else if (i >= int'(HEIGHT_OFS) && i < int'(HEIGHT_OFS) + 4) begin
                b = h[8 * (i - int'(HEIGHT_OFS)) +: 8];
            end else begin
                b = 8'($urandom());
            end
            send_byte(b, i == 0);
        end
        // Alternating all-zero and all-one bytes when a pattern is asked for
        for (i = 0; i < body_len; i++) begin
            b = pattern ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom());
            send_byte(b, 1'b0);
        end
    endtask

    // Drop valid, wait for all owed writes, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write both origins while the stream is idle
    task automatic configure(input logic [ORIGIN_X_W-1:0] ox, input logic [ORIGIN_X_W-1:0] oy);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_ORIGIN_X;
        cfg_data  <= ox;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_origin(CFG_ORIGIN_X, ox);
        cfg_index <= CFG_ORIGIN_Y;
        cfg_data  <= oy;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_origin(CFG_ORIGIN_Y, oy);
        cfg_valid <= 1'b0;
    endtask

    // One random file: mostly well-formed, some cut short, empty or oversized
    task automatic random_file();
        int          r;
        logic [31:0] w;
        logic [31:0] h;
        r = $urandom_range(0, 99);
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 8);
        if (r < 65) begin
            send_file(w, h, 54, int'(3 * w * h) +
                      ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0), 1'b0);
        end else if (r < 75) begin
            if ($urandom_range(0, 1) == 0) begin
                send_file(w, h, $urandom_range(1, 53), 0, 1'b0);
            end else begin
                send_file(w, h, 54, $urandom_range(0, int'(3 * w * h) - 1), 1'b0);
            end
        end else if (r < 83) begin
            if ($urandom_range(0, 1) == 0) begin
                w = '0;
            end else begin
                h = '0;
            end
            send_file(w, h, 54, $urandom_range(0, 12), 1'b0);
        end else if (r < 93) begin
            case ($urandom_range(0, 2))
                0: w = $urandom_range(800, 2000);
                1: w = $urandom() | 32'h8000_0000;
                default: h = $urandom() | 32'h8000_0000;
            endcase
            send_file(w, h, 54, 3 * $urandom_range(1, 40), 1'b0);
        end else begin
            send_file($urandom(), $urandom(), 54, $urandom_range(0, 60), 1'b0);
        end
    endtask

    // Receiver: check each transfer, stall at random, hold off once for a long stretch
    initial begin : receiver
        int        stall_left;
        int        hold_left;
        bit        hold_done;
        fb_write_t got;
        stall_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = '{m_tuser, m_tdata[ADDR_W-1:0], m_tdata[ADDR_W+ARGB_W-1:ADDR_W], m_tlast};
                sb.check_write(got, m_tdata[M_DATA_W-1:ADDR_W+ARGB_W]);
            end
            if (hold_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                stall_left = idle_len() - 1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("bmp24_framebuffer_blit_test: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int file_no;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Extreme pixel bytes at reset origins, then bytes after the last pixel
        send_file(32'd2, 32'd2, 54, 12 + 3, 1'b1);
        // Bottom-right corner: only the top-left pixel lands on screen
        configure(10'd799, 10'd479);
        send_file(32'd2, 32'd2, 54, 12, 1'b0);
        // Empty images
        send_file(32'd0, 32'd3, 54, 6, 1'b0);
        send_file(32'd3, 32'd0, 54, 6, 1'b0);
        // Restart in the header, then in the middle of a pixel
        send_file(32'd3, 32'd2, 20, 0, 1'b0);
        send_file(32'd3, 32'd2, 54, 4, 1'b0);
        send_file(32'd3, 32'd2, 54, 18, 1'b0);
        // Origin past the screen edge: everything is clipped
        configure(10'd1023, 10'h3FF);
        send_file(32'd4, 32'd2, 54, 24, 1'b0);
        // Huge width shows on row zero; huge height clips every row
        configure(10'd0, 10'd0);
        send_file(32'hFFFF_FFFF, 32'd1, 54, 9, 1'b0);
        send_file(32'd2, 32'hFFFF_FFFF, 54, 9, 1'b0);

        // Random files with periodic origin changes
        file_no = 0;
        while (live_items < ITEM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            if (file_no % 3 == 0) begin
                configure(pick_origin(799, 1023),
                          {1'($urandom()), ORIGIN_Y_W'(pick_origin(479, 511))});
            end
            if (file_no == 4) begin
                // Keep offering a large image while the receiver holds off
                steady   = 1'b1;
                hold_req = 1'b1;
                send_file(32'd10, 32'd8, 54, 240, 1'b0);
            end else begin
                random_file();
            end
            file_no++;
        end

        settle();
        if (sb.errors == 0) begin
            $display("bmp24_framebuffer_blit_test: done, clean");
        end else begin
            $display("bmp24_framebuffer_blit_test: done, errors");
        end
        $finish;
    end

endmodule
